// File: rtl/osc_pkg.sv
// ----------------------------------------------------------------------------
// osc_pkg
// Types and constants shared by the stream compaction block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package osc_pkg;

  localparam int          VALUE_W       = 32;
  localparam int          COUNT_W       = 7;
  localparam int          CFG_ADDR_W    = 2;
  localparam int          CFG_DATA_W    = 32;
  localparam int          RESULT_CAP    = 64;
  localparam logic [COUNT_W-1:0] OUT_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [VALUE_W-1:0] item_value;
    logic               drop_tag;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic               out_last;
  } out_item_t;

  typedef struct packed {
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
  } apb_req_t;

endpackage

`default_nettype wire

// File: rtl/osc_ram.sv
// ----------------------------------------------------------------------------
// osc_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osc_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 39
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [DW-1:0]            wdata,
  input  wire                      re,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/osc_regs.sv
// ----------------------------------------------------------------------------
// osc_regs
// Configuration register file: holds out_count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osc_regs (
  input  wire                              clk,
  input  wire                              rst_n,
  input  osc_pkg::apb_req_t                apb,
  output logic [osc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic [osc_pkg::COUNT_W-1:0]      out_count
);
  import osc_pkg::*;

  logic [COUNT_W-1:0] out_count_r;
  logic [COUNT_W-1:0] out_count_nxt;

  always_comb begin
    out_count_nxt = out_count_r;
    if (apb.psel && apb.penable && apb.pwrite) begin
      out_count_nxt = apb.pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_count_r <= OUT_COUNT_RST;
    end else begin
      out_count_r <= out_count_nxt;
    end
  end

  assign out_count = out_count_r;
  assign prdata    = CFG_DATA_W'(out_count_r);

endmodule

`default_nettype wire

// File: rtl/oblivious_stream_compaction.sv
// ----------------------------------------------------------------------------
// oblivious_stream_compaction
// Loads a run of tagged items, closes the gaps of dropped items with a
// log shifter run in place over one element store, then emits the front.
// ----------------------------------------------------------------------------
//  channel  direction  payload      handshake
//  in_      input      in_item_t    in_valid / in_stall
//  out_     output     out_item_t   out_valid / out_stall
//  cfg      input      APB write    psel & penable & pwrite (pready high)
//
// After the last item, shifter level i moves elements by 2^i, for
// floor(log2 n) levels, one element per cycle through the store's single
// read and write port. Emit reads each value, then loads the output
// register while out_stall allows. in_stall is high from the last item
// until the final value is loaded (the shifter ends, if limit is zero).
// Reset clears state, counters, out_valid; the store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oblivious_stream_compaction #(
  parameter int MAX_ITEMS = 64
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  osc_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output osc_pkg::out_item_t               out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [osc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [osc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [osc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import osc_pkg::*;

  localparam int AW        = $clog2(MAX_ITEMS);
  localparam int CW        = $clog2(MAX_ITEMS + 1);
  localparam int DW        = VALUE_W + CW;
  localparam int KW        = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int LIMIT_CAP = (MAX_ITEMS < RESULT_CAP) ? MAX_ITEMS : RESULT_CAP;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_NET  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LD   = 4'b1000
  } state_t;

  apb_req_t           apb;
  logic [COUNT_W-1:0] out_count;
  logic [COUNT_W-1:0] limit;

  state_t        state_r, state_nxt;
  logic [CW-1:0] run_len_r, run_len_nxt;
  logic [CW-1:0] tag_total_r, tag_total_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] jump_r, jump_nxt;
  logic          p_r, p_nxt;
  logic [AW-1:0] pj_r, pj_nxt;
  logic [COUNT_W-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic          accept, store_it;
  logic [CW-1:0] tag_sum, src;
  logic          k_in_run;
  logic          out_free;

  assign apb = '{psel: psel, penable: penable, pwrite: pwrite, paddr: paddr, pwdata: pwdata};
  assign pready = 1'b1;

  osc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .apb       (apb),
    .prdata    (prdata),
    .out_count (out_count)
  );

  osc_ram #(
    .DEPTH (MAX_ITEMS),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign limit    = (out_count > COUNT_W'(LIMIT_CAP)) ? COUNT_W'(LIMIT_CAP) : out_count;
  assign in_stall = (state_r != ST_LOAD);
  assign accept   = in_valid && !in_stall;
  assign store_it = run_len_r < CW'(MAX_ITEMS);
  assign tag_sum  = tag_total_r + CW'(in_data.drop_tag);
  assign src      = j_r + jump_r;
  assign k_in_run = KW'(k_r) < KW'(n_r);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    run_len_nxt   = run_len_r;
    tag_total_nxt = tag_total_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    jump_nxt      = jump_r;
    p_nxt         = 1'b0;
    pj_nxt        = pj_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = AW'(run_len_r);
    wdata         = {in_data.item_value, tag_sum};
    re            = 1'b0;
    raddr         = AW'(src);

    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          we = store_it;
          if (store_it) begin
            run_len_nxt   = run_len_r + CW'(1);
            tag_total_nxt = tag_sum;
          end
          if (in_data.last_item) begin
            n_nxt         = store_it ? run_len_r + CW'(1) : run_len_r;
            run_len_nxt   = '0;
            tag_total_nxt = '0;
            j_nxt         = '0;
            jump_nxt      = CW'(1);
            k_nxt         = '0;
            if (n_nxt >= CW'(2)) begin
              state_nxt = ST_NET;
            end else if (limit != '0) begin
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_NET: begin
        // write back the element read last cycle if its move bit is set
        waddr = pj_r;
        wdata = rdata;
        we    = p_r && ((rdata[CW-1:0] & jump_r) != '0);
        if (src < n_r) begin
          re     = 1'b1;
          p_nxt  = 1'b1;
          pj_nxt = AW'(j_r);
          j_nxt  = j_r + CW'(1);
        end else begin
          j_nxt    = '0;
          jump_nxt = jump_r << 1;
          if ({jump_r, 2'b00} > (CW+2)'(n_r)) begin
            state_nxt = (limit != '0) ? ST_RD : ST_LOAD;
          end
        end
      end
      ST_RD: begin
        raddr     = AW'(k_r);
        re        = k_in_run;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_value = k_in_run ? rdata[DW-1:CW] : '0;
          out_data_nxt.out_last  = (k_r + COUNT_W'(1)) == limit;
          k_nxt                  = k_r + COUNT_W'(1);
          state_nxt              = out_data_nxt.out_last ? ST_LOAD : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      run_len_r   <= '0;
      tag_total_r <= '0;
      p_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_len_r   <= run_len_nxt;
      tag_total_r <= tag_total_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    jump_r     <= jump_nxt;
    pj_r       <= pj_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/osc_checker.sv
// ----------------------------------------------------------------------------
// osc_assert
// Port-level checks on the stream compaction block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module osc_assert (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input osc_pkg::in_item_t  in_data,
  input wire                out_valid,
  input wire                out_stall,
  input osc_pkg::out_item_t out_data
);
  import osc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output item produced while loading");

  a_reset_state: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind oblivious_stream_compaction osc_assert u_osc_assert (.*);

`default_nettype wire
